>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> design/fvpu_pkg.sv
// ----------------------------------------------------------------------------
// fvpu_pkg
// Types, constants and fixed-point helpers for the flock update block.
// ----------------------------------------------------------------------------
package fvpu_pkg;

	localparam int MAX_AGENTS_DEF = 64;

	typedef logic signed [31:0] q16_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// register addresses (paddr[2])
	localparam logic REG_AGENT_COUNT = 1'b0;
	localparam logic REG_BOX_LIMIT   = 1'b1;

	// Q16.16 gains; wall term folds to -2*0.1*p since the box cancels
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 19;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = PROD_W + 2;

	localparam logic signed [MUL_B_W-1:0] K_WALL2 = -19'sd13108;
	localparam logic signed [MUL_B_W-1:0] K_COH   = 19'sd144179;
	localparam logic signed [MUL_B_W-1:0] K_ALIGN = 19'sd32768;
	localparam logic signed [MUL_B_W-1:0] K_SCALE = 19'sd72090;
	localparam logic signed [MUL_B_W-1:0] K_STEP  = 19'sd655;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = 55'sd32768;
	localparam q16_t Q_MAX = 32'sh7fffffff;
	localparam q16_t Q_MIN = 32'sh80000000;

	typedef struct packed {
		logic       op;
		logic [5:0] agent_index;
		q16_t       pos_x;
		q16_t       pos_y;
		q16_t       pos_z;
		q16_t       vel_x;
		q16_t       vel_y;
		q16_t       vel_z;
	} in_word_t;

	typedef struct packed {
		logic [5:0] out_index;
		q16_t       new_pos_x;
		q16_t       new_pos_y;
		q16_t       new_pos_z;
		q16_t       new_vel_x;
		q16_t       new_vel_y;
		q16_t       new_vel_z;
		logic       last_agent;
	} out_word_t;

	// one table row: position and velocity per axis
	typedef struct packed {
		q16_t [2:0] p;
		q16_t [2:0] v;
	} row_t;

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b00000001,
		ST_SUM_RD  = 8'b00000010,
		ST_SUM_ACC = 8'b00000100,
		ST_UPD_RD  = 8'b00001000,
		ST_DIV_LD  = 8'b00010000,
		ST_DIV_RUN = 8'b00100000,
		ST_MUL     = 8'b01000000,
		ST_EMIT    = 8'b10000000
	} state_t;

	typedef enum logic [3:0] {
		MS_WALL, MS_COH, MS_ALIGN, MS_SUM, MS_DELTA, MS_SCALE,
		MS_SCALED, MS_DV, MS_NV, MS_DP, MS_NP
	} mstep_t;

	// round to nearest (ties up) from 2^-32 units to Q16.16, saturate
	function automatic q16_t rnd_sat(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] r;
		r = x + ROUND_HALF;
		r = r >>> 16;
		if ((&r[ACC_W-1:31]) || !(|r[ACC_W-1:31]))
			return r[31:0];
		return r[ACC_W-1] ? Q_MIN : Q_MAX;
	endfunction

	function automatic q16_t sat_add(input q16_t a, input q16_t b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31])
			return s[32] ? Q_MIN : Q_MAX;
		return s[31:0];
	endfunction

endpackage

>>> design/fvpu_chan_if.sv
// ----------------------------------------------------------------------------
// fvpu_chan_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface fvpu_chan_if #(
	parameter type word_t = logic
) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> design/flock_velocity_position_update_top.sv
// ----------------------------------------------------------------------------
// flock_velocity_position_update_top
// Boids-style velocity/position update over an agent table, Q16.16 fixed point.
// ----------------------------------------------------------------------------
//  channel  dir  word        notes
//  in_ch    in   in_word_t   op 0 = load one agent row, op 1 = run one step
//  out_ch   out  out_word_t  one word per agent on a step, index order
//  apb      in   32b regs    0x0 agent_count, 0x4 box_limit
//
//  Load: row written on acceptance, next word accepted the following cycle.
//  Step: a summing pass, then per agent and axis the position and velocity
//  means from the shared bit-serial divider (n > 1; NW = $clog2(MAX_AGENTS)
//  + 36 quotient bits) and a sequence on the single shared multiplier.
//  in_ch is not ready while a step runs; out_ch stalls simply hold EMIT.
//  No clearing pass after reset; agent_count resets to 1, box_limit to 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flock_velocity_position_update_top
	import fvpu_pkg::*;
#(
	parameter int MAX_AGENTS = MAX_AGENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	fvpu_chan_if.sink   in_ch,
	fvpu_chan_if.source out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW  = $clog2(MAX_AGENTS);
	localparam int CW  = $clog2(MAX_AGENTS + 1);
	localparam int SW  = 32 + AW + 1;     // sum over the table
	localparam int NW  = SW + 3;          // 2*(sum - own) + m
	localparam int DW  = CW + 2;          // divider remainder
	localparam int DCW = $clog2(NW + 1);

	// ---------------- config registers
	logic [6:0] agent_count_q;
	q16_t       box_limit_q;
	logic       cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_BOX_LIMIT) ? box_limit_q : {25'b0, agent_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agent_count_q <= 7'd1;
			box_limit_q   <= '0;
		end else if (cfg_we) begin
			if (paddr[2] == REG_AGENT_COUNT)
				agent_count_q <= pwdata[6:0];
			else
				box_limit_q <= pwdata;
		end
	end

	// ---------------- control state
	state_t          state_q;
	mstep_t          ms_q;
	logic [AW-1:0]   idx_q;
	logic [CW-1:0]   n_q;
	logic [1:0]      ax_q;
	logic            sel_q;      // 0 position mean, 1 velocity mean
	logic [DCW-1:0]  div_cnt_q;

	logic in_acc, out_acc, load_we;
	logic [AW-1:0] last_idx;
	logic [CW-1:0] m_w;
	logic [CW-1:0] n_next;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_acc     = out_ch.valid && out_ch.ready;
	assign load_we     = in_acc && (in_ch.data.op == OP_LOAD)
		&& (32'(in_ch.data.agent_index) < 32'(MAX_AGENTS));
	assign last_idx    = AW'(n_q - CW'(1));
	assign m_w         = n_q - CW'(1);

	always_comb begin
		if (agent_count_q == 7'd0)
			n_next = CW'(1);
		else if (32'(agent_count_q) > 32'(MAX_AGENTS))
			n_next = CW'(MAX_AGENTS);
		else
			n_next = CW'(agent_count_q);
	end

	// ---------------- agent table
	row_t mem_q [MAX_AGENTS];
	row_t rd_row_q;
	row_t new_row_q;
	row_t mem_wdata;
	logic mem_we;
	logic [AW-1:0] mem_waddr;

	assign mem_we = load_we || (state_q == ST_EMIT && out_acc);

	always_comb begin
		if (state_q == ST_IDLE) begin
			mem_waddr   = AW'(in_ch.data.agent_index);
			mem_wdata.p = {in_ch.data.pos_z, in_ch.data.pos_y, in_ch.data.pos_x};
			mem_wdata.v = {in_ch.data.vel_z, in_ch.data.vel_y, in_ch.data.vel_x};
		end else begin
			mem_waddr = idx_q;
			mem_wdata = new_row_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_waddr] <= mem_wdata;
		rd_row_q <= mem_q[idx_q];
	end

	// ---------------- datapath
	logic signed [SW-1:0] sum_p_q [3];
	logic signed [SW-1:0] sum_v_q [3];
	logic [DW-1:0]        rem_q;
	logic [NW-1:0]        quo_q;
	logic                 neg_q;
	logic signed [MUL_A_W-1:0] mp_q, mv_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	q16_t t_q, nv_q;

	q16_t p_w, v_w;
	logic signed [SW-1:0] s_w;
	q16_t x_w;
	logic signed [NW-1:0] num_w;
	logic [NW-1:0] mag_w;
	logic [DW-1:0] den_w, rsh_w;
	logic [NW-1:0] qmag_w;
	logic signed [NW-1:0] qs_w;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	q16_t rnd_prod_w;

	assign p_w   = rd_row_q.p[ax_q];
	assign v_w   = rd_row_q.v[ax_q];
	assign s_w   = sel_q ? sum_v_q[ax_q] : sum_p_q[ax_q];
	assign x_w   = sel_q ? v_w : p_w;
	assign num_w = ((NW'(s_w) - NW'(x_w)) <<< 1) + $signed(NW'(m_w));
	assign mag_w = num_w[NW-1] ? NW'(-num_w) : NW'(num_w);
	assign den_w = DW'({m_w, 1'b0});
	assign rsh_w = {rem_q[DW-2:0], quo_q[NW-1]};
	assign qmag_w = quo_q + NW'(rem_q != '0);
	assign qs_w  = neg_q ? -$signed(qmag_w) : $signed(quo_q);
	assign rnd_prod_w = rnd_sat(ACC_W'(prod_q));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ms_q)
			MS_WALL: begin
				mul_a = MUL_A_W'(p_w);
				mul_b = K_WALL2;
			end
			MS_COH: begin
				mul_a = mp_q - MUL_A_W'(p_w);
				mul_b = K_COH;
			end
			MS_ALIGN: begin
				mul_a = mv_q;
				mul_b = K_ALIGN;
			end
			MS_SCALE: begin
				mul_a = MUL_A_W'(t_q);
				mul_b = K_SCALE;
			end
			MS_DV: begin
				mul_a = MUL_A_W'(t_q);
				mul_b = K_STEP;
			end
			MS_DP: begin
				mul_a = MUL_A_W'(nv_q);
				mul_b = K_STEP;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_ch.data.op == OP_STEP) begin
			for (int k = 0; k < 3; k++) begin
				sum_p_q[k] <= '0;
				sum_v_q[k] <= '0;
			end
		end
		if (state_q == ST_SUM_ACC) begin
			for (int k = 0; k < 3; k++) begin
				sum_p_q[k] <= sum_p_q[k] + SW'(rd_row_q.p[k]);
				sum_v_q[k] <= sum_v_q[k] + SW'(rd_row_q.v[k]);
			end
		end
		if (state_q == ST_DIV_LD) begin
			rem_q <= '0;
			quo_q <= mag_w;
			neg_q <= num_w[NW-1];
			if (m_w == '0) begin
				mp_q <= '0;
				mv_q <= '0;
			end
		end
		if (state_q == ST_DIV_RUN) begin
			if (div_cnt_q != DCW'(NW)) begin
				if (rsh_w >= den_w) begin
					rem_q <= rsh_w - den_w;
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= rsh_w;
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
			end else if (sel_q) begin
				mv_q <= MUL_A_W'(qs_w);
			end else begin
				mp_q <= MUL_A_W'(qs_w);
			end
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_a * mul_b;
			case (ms_q)
				MS_COH:    acc_q <= ACC_W'(prod_q);
				MS_ALIGN:  acc_q <= acc_q + ACC_W'(prod_q);
				MS_SUM:    acc_q <= acc_q + ACC_W'(prod_q);
				MS_DELTA:  t_q <= rnd_sat(acc_q);
				MS_SCALED: t_q <= rnd_prod_w;
				MS_NV:     nv_q <= sat_add(v_w, rnd_prod_w);
				MS_NP: begin
					new_row_q.p[ax_q] <= sat_add(p_w, rnd_prod_w);
					new_row_q.v[ax_q] <= nv_q;
				end
				default: acc_q <= acc_q;
			endcase
		end
	end

	// ---------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ms_q      <= MS_WALL;
			idx_q     <= '0;
			n_q       <= CW'(1);
			ax_q      <= '0;
			sel_q     <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_ch.data.op == OP_STEP) begin
						n_q     <= n_next;
						idx_q   <= '0;
						state_q <= ST_SUM_RD;
					end
				end
				ST_SUM_RD: state_q <= ST_SUM_ACC;
				ST_SUM_ACC: begin
					if (idx_q == last_idx) begin
						idx_q   <= '0;
						state_q <= ST_UPD_RD;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_SUM_RD;
					end
				end
				ST_UPD_RD: begin
					ax_q    <= '0;
					sel_q   <= 1'b0;
					state_q <= ST_DIV_LD;
				end
				ST_DIV_LD: begin
					div_cnt_q <= '0;
					if (m_w == '0) begin
						ms_q    <= MS_WALL;
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_DIV_RUN;
					end
				end
				ST_DIV_RUN: begin
					if (div_cnt_q != DCW'(NW)) begin
						div_cnt_q <= div_cnt_q + DCW'(1);
					end else if (!sel_q) begin
						sel_q   <= 1'b1;
						state_q <= ST_DIV_LD;
					end else begin
						ms_q    <= MS_WALL;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (ms_q == MS_NP) begin
						sel_q <= 1'b0;
						if (ax_q == 2'd2) begin
							state_q <= ST_EMIT;
						end else begin
							ax_q    <= ax_q + 2'd1;
							state_q <= ST_DIV_LD;
						end
					end else begin
						ms_q <= mstep_t'(ms_q + 4'd1);
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						if (idx_q == last_idx) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= ST_UPD_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- result word
	assign out_ch.valid = (state_q == ST_EMIT);
	assign out_ch.data.out_index  = 6'(idx_q);
	assign out_ch.data.new_pos_x  = new_row_q.p[0];
	assign out_ch.data.new_pos_y  = new_row_q.p[1];
	assign out_ch.data.new_pos_z  = new_row_q.p[2];
	assign out_ch.data.new_vel_x  = new_row_q.v[0];
	assign out_ch.data.new_vel_y  = new_row_q.v[1];
	assign out_ch.data.new_vel_z  = new_row_q.v[2];
	assign out_ch.data.last_agent = (idx_q == last_idx);

	// ---------------- checks
	`ASSERT_NXT(a_step_starts_sum, in_acc && in_ch.data.op == OP_STEP, state_q == ST_SUM_RD)
	`ASSERT_IMP(a_div_count_bound, state_q == ST_DIV_RUN, div_cnt_q <= DCW'(NW))
	`ASSERT_IMP(a_idx_in_range, state_q != ST_IDLE, idx_q <= last_idx)
	`ASSERT_NXT(a_emit_stall_keeps, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(idx_q))

endmodule
